[rtl/core/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, character codes and helpers for the serial command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam int unsigned TIME_LEN = 12;
  localparam int unsigned TIDX_W   = 4;

  localparam logic [1:0] HALT_STARS = 2'd3;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_I     = 8'h49;

  localparam logic [1:0] SYS_LOOP = 2'd0;
  localparam logic [1:0] SYS_HALT = 2'd1;

  typedef enum logic [1:0] {
    MODE_LOOP,
    MODE_HALT,
    MODE_OTHER
  } mode_t;

  typedef enum logic [2:0] {
    CLS_STAR,
    CLS_QUERY,
    CLS_CR,
    CLS_LF,
    CLS_A,
    CLS_T,
    CLS_I,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_CMD,
    PS_PAYLOAD,
    PS_CR,
    PS_LF
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DATA,
    KIND_TIME,
    KIND_SYNC
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HALT,
    ACT_DATA,
    ACT_TIME,
    ACT_SYNC
  } action_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    mode_t      mode;
    cls_t       cls;
  } token_t;

  // 10 * (hi - '0') + (lo - '0'), mod 256
  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CH_ZERO;
    l = lo - CH_ZERO;
    return (h << 3) + (h << 1) + l;
  endfunction

endpackage

[rtl/core/scp_front.sv]
// ----------------------------------------------------------------------------
// scp_front
// Classifies each received byte and its system mode into a parser token.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic            [7:0] rx_byte,
  input  logic            [1:0] system_mode,
  output scp_pkg::token_t       token
);

  scp_pkg::cls_t  cls;
  scp_pkg::mode_t mode;

  always_comb begin
    unique case (rx_byte)
      scp_pkg::CH_STAR:  cls = scp_pkg::CLS_STAR;
      scp_pkg::CH_QUERY: cls = scp_pkg::CLS_QUERY;
      scp_pkg::CH_CR:    cls = scp_pkg::CLS_CR;
      scp_pkg::CH_LF:    cls = scp_pkg::CLS_LF;
      scp_pkg::CH_A:     cls = scp_pkg::CLS_A;
      scp_pkg::CH_T:     cls = scp_pkg::CLS_T;
      scp_pkg::CH_I:     cls = scp_pkg::CLS_I;
      default:           cls = scp_pkg::CLS_OTHER;
    endcase
  end

  always_comb begin
    unique case (system_mode)
      scp_pkg::SYS_LOOP: mode = scp_pkg::MODE_LOOP;
      scp_pkg::SYS_HALT: mode = scp_pkg::MODE_HALT;
      default:           mode = scp_pkg::MODE_OTHER;
    endcase
  end

  assign token = '{rx_byte: rx_byte, mode: mode, cls: cls};

endmodule

[rtl/core/scp_queue.sv]
// ----------------------------------------------------------------------------
// scp_queue
// Two-entry token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module scp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scp_pkg::token_t push_token,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output scp_pkg::token_t pop_token
);

  localparam int unsigned CNT_W = scp_pkg::QUEUE_AW + 1;

  scp_pkg::token_t               mem [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [scp_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [CNT_W-1:0]              count;

  assign full      = (count == CNT_W'(scp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_token = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

[rtl/core/scp_back.sv]
// ----------------------------------------------------------------------------
// scp_back
// Command parser state machine with time digit store and result register.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  input  scp_pkg::token_t tok,
  output logic            tok_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,   // data_digit, day, month, year, hour, minute, second
  output logic [2:0]      m_tuser    // action
);

  scp_pkg::parse_state_t        state, state_next;
  scp_pkg::kind_t               kind, kind_next;
  logic [7:0]                   digit, digit_next;
  logic [scp_pkg::TIDX_W-1:0]   tidx, tidx_next, tidx_inc;
  logic [1:0]                   star, star_next, star_inc;
  logic [7:0]                   tdig [scp_pkg::TIME_LEN];
  logic                         tdig_we;
  scp_pkg::action_t             act;
  logic                         advance;
  logic [47:0]                  time_fields;

  assign tok_ready = !m_tvalid || m_tready;
  assign advance   = tok_valid && tok_ready;
  assign star_inc  = star + 2'd1;
  assign tidx_inc  = tidx + 1'b1;

  // next parse state
  always_comb begin
    state_next = state;
    if (tok.mode == scp_pkg::MODE_HALT) begin
      unique case (state)
        scp_pkg::PS_IDLE: begin
          if (tok.cls == scp_pkg::CLS_QUERY) state_next = scp_pkg::PS_CMD;
        end
        scp_pkg::PS_CMD: begin
          if (tok.cls == scp_pkg::CLS_A || tok.cls == scp_pkg::CLS_T ||
              tok.cls == scp_pkg::CLS_I) begin
            state_next = scp_pkg::PS_PAYLOAD;
          end else begin
            state_next = scp_pkg::PS_IDLE;
          end
        end
        scp_pkg::PS_PAYLOAD: begin
          unique case (kind) inside
            scp_pkg::KIND_DATA, scp_pkg::KIND_SYNC: state_next = scp_pkg::PS_CR;
            scp_pkg::KIND_TIME: begin
              if (tidx_inc >= scp_pkg::TIDX_W'(scp_pkg::TIME_LEN)) state_next = scp_pkg::PS_CR;
            end
            default: state_next = scp_pkg::PS_IDLE;
          endcase
        end
        scp_pkg::PS_CR: begin
          state_next = (tok.cls == scp_pkg::CLS_CR) ? scp_pkg::PS_LF : scp_pkg::PS_IDLE;
        end
        default: state_next = scp_pkg::PS_IDLE;
      endcase
    end
  end

  // actions and parser data
  always_comb begin
    kind_next  = kind;
    digit_next = digit;
    tidx_next  = tidx;
    star_next  = star;
    tdig_we    = 1'b0;
    act        = scp_pkg::ACT_NONE;
    unique case (tok.mode)
      scp_pkg::MODE_LOOP: begin
        if (tok.cls == scp_pkg::CLS_STAR) begin
          if (star_inc == scp_pkg::HALT_STARS) begin
            star_next = 2'd0;
            act       = scp_pkg::ACT_HALT;
          end else begin
            star_next = star_inc;
          end
        end
      end
      scp_pkg::MODE_HALT: begin
        unique case (state)
          scp_pkg::PS_IDLE: begin
            if (tok.cls == scp_pkg::CLS_STAR) begin
              if (star_inc == scp_pkg::HALT_STARS) begin
                star_next = 2'd0;
                act       = scp_pkg::ACT_HALT;
              end else begin
                star_next = star_inc;
              end
            end else if (tok.cls != scp_pkg::CLS_QUERY) begin
              star_next = 2'd0;
            end
          end
          scp_pkg::PS_CMD: begin
            unique case (tok.cls)
              scp_pkg::CLS_A: kind_next = scp_pkg::KIND_DATA;
              scp_pkg::CLS_T: begin
                kind_next = scp_pkg::KIND_TIME;
                tidx_next = '0;
              end
              scp_pkg::CLS_I: kind_next = scp_pkg::KIND_SYNC;
              default: ;
            endcase
          end
          scp_pkg::PS_PAYLOAD: begin
            if (kind == scp_pkg::KIND_DATA) begin
              digit_next = tok.rx_byte - scp_pkg::CH_ZERO;
            end else if (kind == scp_pkg::KIND_TIME) begin
              tdig_we   = (tidx < scp_pkg::TIDX_W'(scp_pkg::TIME_LEN));
              tidx_next = tidx_inc;
            end
          end
          scp_pkg::PS_LF: begin
            if (tok.cls == scp_pkg::CLS_LF) begin
              unique case (kind)
                scp_pkg::KIND_DATA: act = scp_pkg::ACT_DATA;
                scp_pkg::KIND_TIME: act = scp_pkg::ACT_TIME;
                scp_pkg::KIND_SYNC: act = scp_pkg::ACT_SYNC;
                default:            act = scp_pkg::ACT_NONE;
              endcase
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      time_fields[8*i +: 8] = scp_pkg::pair_value(tdig[2*i], tdig[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scp_pkg::PS_IDLE;
      kind  <= scp_pkg::KIND_NONE;
      digit <= '0;
      tidx  <= '0;
      star  <= '0;
    end else if (advance) begin
      state <= state_next;
      kind  <= kind_next;
      digit <= digit_next;
      tidx  <= tidx_next;
      star  <= star_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tdig_we) begin
      tdig[tidx] <= tok.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser        <= act;
      m_tdata[7:0]   <= (act == scp_pkg::ACT_DATA) ? digit : 8'd0;
      m_tdata[55:8]  <= (act == scp_pkg::ACT_TIME) ? time_fields : 48'd0;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("accepted token produced no result");

  a_time_len: assert property (@(posedge clk) disable iff (rst)
    (state == scp_pkg::PS_CR && kind == scp_pkg::KIND_TIME) |->
      tidx == scp_pkg::TIDX_W'(scp_pkg::TIME_LEN))
    else $error("time payload ended at wrong length");

  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    (state == scp_pkg::PS_PAYLOAD || state == scp_pkg::PS_CR || state == scp_pkg::PS_LF)
      |-> kind != scp_pkg::KIND_NONE)
    else $error("payload without request kind");

  a_star_below: assert property (@(posedge clk) disable iff (rst)
    $past(advance) && $past(act) == scp_pkg::ACT_HALT |-> star == 2'd0)
    else $error("star count not cleared on halt request");

endmodule

[rtl/core/serial_command_parser.sv]
// ----------------------------------------------------------------------------
// serial_command_parser
// Star-count halt detection and '?A', '?T', '?I' command parsing on bytes.
// ----------------------------------------------------------------------------
// Accepted bytes are held in the token queue, then in the result register.
// One byte per cycle unless m_tready stalls; parser state updates in one step.
// A two-entry token queue sits between classifier and parser, so input keeps
// accepting up to two bytes while the result register waits on m_tready.
// Reset (rst, synchronous): parser idle, counts and queue cleared, no result.
// ----------------------------------------------------------------------------
module serial_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // system_mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // data_digit, day, month, year, hour, minute, second
  output logic [2:0]  m_tuser    // action
);

  scp_pkg::token_t in_token;
  scp_pkg::token_t q_token;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  scp_front u_front (
    .rx_byte     (s_tdata),
    .system_mode (s_tuser),
    .token       (in_token)
  );

  scp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (in_token),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .pop_token  (q_token)
  );

  logic tok_ready;
  assign q_pop = q_valid && tok_ready;

  scp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_token),
    .tok_ready (tok_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[tb/scp_checker.sv]
// ----------------------------------------------------------------------------
// scp_checker
// Watches both streams of the serial command parser. It predicts the reply
// to each accepted byte with its own copy of the parser state and compares
// every returned reply, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_checker
  import scp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // system_mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // data_digit, day, month, year, hour, minute, second
  input  logic [2:0]  m_tuser,   // action
  output int          errors,
  output int          outstanding,
  output int          replies_checked,
  output int          commands_done,
  output int          halts_done
);

  // f[0] is data_digit, f[1..6] day through second, same order as m_tdata
  typedef struct packed {
    action_t         act;
    logic [6:0][7:0] f;
  } reply_t;

  string field_name [0:6] = '{"data_digit", "day", "month", "year",
                              "hour", "minute", "second"};

  parse_state_t ps;
  kind_t        kind;
  logic [7:0]   digit;
  logic [7:0]   stamp [0:TIME_LEN-1];
  logic [3:0]   tidx;
  logic [1:0]   stars;

  reply_t replies_due [$];
  reply_t got;
  reply_t want;
  int     err_cnt;
  int     n_checked;
  int     n_cmds;
  int     n_halts;

  function automatic logic star_hit();
    stars = stars + 2'd1;
    if (stars == HALT_STARS) begin
      stars = 2'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic [1:0] mode, output reply_t r);
    logic [7:0] hi;
    logic [7:0] lo;
    r = '0;
    if (mode == SYS_LOOP) begin
      if (b == CH_STAR && star_hit())
        r.act = ACT_HALT;
    end else if (mode == SYS_HALT) begin
      case (ps)
        PS_IDLE: begin
          if (b == CH_QUERY) begin
            ps = PS_CMD;
          end else if (b == CH_STAR) begin
            if (star_hit())
              r.act = ACT_HALT;
          end else begin
            stars = 2'd0;
          end
        end
        PS_CMD: begin
          if (b == CH_A) begin
            kind = KIND_DATA;
            ps   = PS_PAYLOAD;
          end else if (b == CH_T) begin
            tidx = '0;
            kind = KIND_TIME;
            ps   = PS_PAYLOAD;
          end else if (b == CH_I) begin
            kind = KIND_SYNC;
            ps   = PS_PAYLOAD;
          end else begin
            ps = PS_IDLE;
          end
        end
        PS_PAYLOAD: begin
          case (kind)
            KIND_DATA: begin
              digit = b - CH_ZERO;
              ps    = PS_CR;
            end
            KIND_TIME: begin
              stamp[tidx] = b;
              tidx = tidx + 4'd1;
              if (tidx >= TIME_LEN)
                ps = PS_CR;
            end
            KIND_SYNC: ps = PS_CR;
            default:   ps = PS_IDLE;
          endcase
        end
        PS_CR: ps = (b == CH_CR) ? PS_LF : PS_IDLE;
        PS_LF: begin
          if (b == CH_LF) begin
            case (kind)
              KIND_DATA: begin
                r.act  = ACT_DATA;
                r.f[0] = digit;
              end
              KIND_TIME: begin
                r.act = ACT_TIME;
                // two ASCII digits per value, wraps at 8 bits
                for (int i = 0; i < 6; i++) begin
                  hi = stamp[2*i] - CH_ZERO;
                  lo = stamp[2*i+1] - CH_ZERO;
                  r.f[i+1] = hi * 8'd10 + lo;
                end
              end
              KIND_SYNC: r.act = ACT_SYNC;
              default: ;
            endcase
          end
          ps = PS_IDLE;
        end
        default: ps = PS_IDLE;
      endcase
    end
  endtask

  initial begin
    err_cnt   = 0;
    n_checked = 0;
    n_cmds    = 0;
    n_halts   = 0;
    errors          = 0;
    outstanding     = 0;
    replies_checked = 0;
    commands_done   = 0;
    halts_done      = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      ps    = PS_IDLE;
      kind  = KIND_NONE;
      digit = '0;
      tidx  = '0;
      stars = '0;
      foreach (stamp[i]) stamp[i] = '0;
      replies_due.delete();
    end else begin
      // retire the reply first: a reply leaving now belongs to an older request
      if (m_tvalid && m_tready) begin
        got.act = action_t'(m_tuser);
        got.f   = m_tdata;
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none due: action %0d data %h", $realtime, m_tuser, m_tdata);
          err_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (got.act !== want.act) begin
            $display("%0t: action expected %0d got %0d", $realtime, want.act, m_tuser);
            err_cnt++;
          end
          for (int i = 0; i < 7; i++) begin
            if (got.f[i] !== want.f[i]) begin
              $display("%0t: %s expected %0d got %0d", $realtime, field_name[i],
                       want.f[i], got.f[i]);
              err_cnt++;
            end
          end
          if (want.act == ACT_HALT)
            n_halts++;
          else if (want.act != ACT_NONE)
            n_cmds++;
          n_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tuser, want);
        replies_due.push_back(want);
      end
    end
    errors          <= err_cnt;
    outstanding     <= replies_due.size();
    replies_checked <= n_checked;
    commands_done   <= n_cmds;
    halts_done      <= n_halts;
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression for serial_command_parser. Drives star runs, well-formed and
// broken '?A', '?T', '?I' commands and noise in all system modes, with random
// gaps on the byte stream and random stalls on the reply stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scp_pkg::*;

  localparam int RUN_ITEMS   = 1950;
  localparam int QUIET_FROM  = 1650;
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] SYS_OTHER = MODE_OTHER;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // rx_byte
  logic [1:0]  s_tuser = '0;   // system_mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // data_digit, day, month, year, hour, minute, second
  logic [2:0]  m_tuser;        // action

  int   errors;
  int   outstanding;
  int   replies_checked;
  int   commands_done;
  int   halts_done;

  logic       calm = 1'b0;
  int         busy_items = 0;
  int         idle_cycles = 0;
  int         out_stall = 0;
  logic [7:0] run_bytes [$];

  serial_command_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  scp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .errors          (errors),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .commands_done   (commands_done),
    .halts_done      (halts_done)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // reply side back-pressure
  always @(posedge clk) begin
    if (out_stall > 0) begin
      m_tready  <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      m_tready  <= 1'b0;
      out_stall <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("serial_command_parser regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // returns at the edge where the byte is taken
  task automatic send(input logic [7:0] b, input logic [1:0] mode);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == SYS_HALT || (mode == SYS_LOOP && b == CH_STAR))
      busy_items++;
  endtask

  task automatic send_command();
    logic [7:0] letter;
    int         pick;
    int         n;
    run_bytes.delete();
    pick = $urandom_range(0, 9);
    letter = (pick < 3) ? CH_A : (pick < 6) ? CH_T : (pick < 9) ? CH_I : 8'($urandom);
    run_bytes.push_back(CH_QUERY);
    run_bytes.push_back(letter);
    n = (letter == CH_T) ? TIME_LEN : 1;
    repeat (n)
      run_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                     : CH_ZERO + 8'($urandom_range(0, 9)));
    run_bytes.push_back(CH_CR);
    run_bytes.push_back(CH_LF);
    // occasionally break the frame: bad letter, bad terminator, stray byte
    if ($urandom_range(0, 7) == 0)
      run_bytes[$urandom_range(0, run_bytes.size() - 1)] = 8'($urandom);
    foreach (run_bytes[i])
      send(run_bytes[i], ($urandom_range(0, 39) == 0) ? 2'($urandom_range(0, 2)) : SYS_HALT);
  endtask

  task automatic send_stars();
    logic [1:0] mode;
    mode = $urandom_range(0, 1) ? SYS_HALT : SYS_LOOP;
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 4) == 0)
        send(8'($urandom), mode);
      send(CH_STAR, mode);
    end
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // loop mode: other bytes keep the count, other mode ignores stars
    send(CH_STAR, SYS_LOOP);
    send(8'hFF, SYS_LOOP);
    send(CH_STAR, SYS_OTHER);
    send(CH_STAR, SYS_LOOP);
    send(CH_STAR, SYS_LOOP);
    // data request with digit wrapping to 0xFF, then time set with odd digits
    run_bytes = '{CH_QUERY, CH_A, 8'h2F, CH_CR, CH_LF,
                  CH_QUERY, CH_T, 8'h39, 8'h39, 8'h30, 8'h30, 8'hFF, 8'h00,
                  8'h31, 8'h32, 8'h35, 8'h39, 8'h30, 8'h39, CH_CR, CH_LF};
    foreach (run_bytes[i])
      send(run_bytes[i], SYS_HALT);

    while (busy_items < RUN_ITEMS) begin
      if (busy_items >= QUIET_FROM)
        calm <= 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 11)
        send_command();
      else if (pick < 16)
        send_stars();
      else
        repeat ($urandom_range(1, 6)) send(8'($urandom), 2'($urandom_range(0, 2)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d parsed bytes, %0d replies checked", busy_items, replies_checked);
    $display("run: %0d halt requests, %0d completed commands", halts_done, commands_done);
    if (errors == 0)
      $display("serial_command_parser regression: pass");
    else
      $display("serial_command_parser regression: fail");
    $finish;
  end

endmodule
